[rtl/sha256_hash_unit_assert.svh]
// assertion macros for the checker file
`ifndef SHA256_HASH_UNIT_ASSERT_SVH
`define SHA256_HASH_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256_hash_unit: check failed");

// next-cycle implication, off while reset is held
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256_hash_unit: check failed");

`endif

[rtl/sha_pkg.sv]
package sha_pkg;

  // source of the byte written into the block
  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_PAD80,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      wr_byte;
    byte_sel_t sel;
    logic      count;
    logic      start;
    logic      round;
    logic [5:0] rnd;
    logic      finish;
    logic [2:0] out_idx;
    logic      clear;
  } sha_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [5:0] pos;
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd7;

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[rtl/sha_ctrl.sv]
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_has_byte,
  input  logic       in_eom,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [2:0] out_idx,
  output logic       out_last,
  input  sha_stat_t  stat,
  output sha_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IN,
    S_COMP,
    S_FIN,
    S_PAD,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       pad_r, pad_nxt;
  logic       first_r, first_nxt;
  logic       len_r, len_nxt;
  logic       done_r, done_nxt;
  logic       full;
  byte_sel_t  pad_sel;

  assign full = (stat.pos == LAST_POS);

  // padding byte choice: marker, then zeros, then length once the final block is reached
  always_comb begin
    if (first_r) begin
      pad_sel = BYTE_PAD80;
    end else if (len_r && (stat.pos >= LEN_POS)) begin
      pad_sel = BYTE_LEN;
    end else begin
      pad_sel = BYTE_ZERO;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    done_nxt  = done_r;
    cmd         = '0;
    cmd.sel     = BYTE_IN;
    cmd.rnd     = rnd_r;
    cmd.out_idx = idx_r;
    case (state_r)
      S_IN: begin
        if (in_tvalid) begin
          if (in_has_byte) begin
            cmd.wr_byte = 1'b1;
            cmd.count   = 1'b1;
          end
          if (in_has_byte && full) begin
            cmd.start = 1'b1;
            rnd_nxt   = '0;
            state_nxt = S_COMP;
          end else if (in_eom) begin
            state_nxt = S_PAD;
          end
          if (in_eom) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
            len_nxt   = 1'b0;
            done_nxt  = 1'b0;
          end
        end
      end
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        cmd.sel     = pad_sel;
        if (first_r) begin
          first_nxt = 1'b0;
          if (stat.pos < LEN_POS) begin
            len_nxt = 1'b1;
          end
        end
        if (full) begin
          cmd.start = 1'b1;
          rnd_nxt   = '0;
          state_nxt = S_COMP;
          if (pad_sel == BYTE_LEN) begin
            done_nxt = 1'b1;
          end else begin
            len_nxt = 1'b1;
          end
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (done_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IN;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (idx_r == LAST_IDX) begin
            cmd.clear = 1'b1;
            pad_nxt   = 1'b0;
            done_nxt  = 1'b0;
            len_nxt   = 1'b0;
            state_nxt = S_IN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      rnd_r   <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      first_r <= 1'b0;
      len_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      done_r  <= done_nxt;
    end
  end

  assign in_tready  = (state_r == S_IN);
  assign out_tvalid = (state_r == S_OUT);
  assign out_idx    = idx_r;
  assign out_last   = (idx_r == LAST_IDX);

endmodule

[rtl/sha_dp.sv]
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [7:0]  in_byte,
  output sha_stat_t   stat,
  output logic [31:0] out_word
);

  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [511:0] block_r, block_nxt;
  logic [31:0]  work_r [0:7];
  logic [31:0]  work_nxt [0:7];
  logic [31:0]  chain_r [0:7];
  logic [31:0]  chain_nxt [0:7];
  logic [7:0]   wr_byte;
  logic [7:0]   len_byte;
  logic [2:0]   len_lane;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  big0, big1, choose, major, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} >> n;
    return tmp[31:0];
  endfunction

  // length bytes go out most significant first
  assign len_lane = ~pos_r[2:0];
  assign len_byte = bits_r[{len_lane, 3'b000} +: 8];

  // byte source select
  always_comb begin
    case (cmd.sel)
      BYTE_IN:    wr_byte = in_byte;
      BYTE_PAD80: wr_byte = PAD_BYTE;
      BYTE_ZERO:  wr_byte = 8'h00;
      BYTE_LEN:   wr_byte = len_byte;
      default:    wr_byte = 8'h00;
    endcase
  end

  // message schedule taps, oldest word at the top
  assign w0  = block_r[511:480];
  assign w1  = block_r[479:448];
  assign w9  = block_r[223:192];
  assign w14 = block_r[63:32];
  assign w_new = (rotr(w14, 5'd17) ^ rotr(w14, 5'd19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 5'd7) ^ rotr(w1, 5'd18) ^ (w1 >> 3)) + w0;

  // one compression round
  assign big1   = rotr(work_r[4], 5'd6) ^ rotr(work_r[4], 5'd11) ^ rotr(work_r[4], 5'd25);
  assign choose = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign t1     = work_r[7] + big1 + choose + sha_k(cmd.rnd) + w0;
  assign big0   = rotr(work_r[0], 5'd2) ^ rotr(work_r[0], 5'd13) ^ rotr(work_r[0], 5'd22);
  assign major  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t2     = big0 + major;

  // next values
  always_comb begin
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    block_nxt = block_r;
    for (int i = 0; i < 8; i++) begin
      work_nxt[i]  = work_r[i];
      chain_nxt[i] = chain_r[i];
    end
    if (cmd.wr_byte) begin
      block_nxt = {block_r[503:0], wr_byte};
      pos_nxt   = pos_r + 6'd1;
    end
    if (cmd.count) begin
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        work_nxt[i] = chain_r[i];
      end
    end
    if (cmd.round) begin
      block_nxt   = {block_r[479:0], w_new};
      work_nxt[0] = t1 + t2;
      work_nxt[1] = work_r[0];
      work_nxt[2] = work_r[1];
      work_nxt[3] = work_r[2];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[5] = work_r[4];
      work_nxt[6] = work_r[5];
      work_nxt[7] = work_r[6];
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end
    if (cmd.clear) begin
      pos_nxt  = '0;
      bits_nxt = '0;
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = SHA_IV[i];
      end
    end
  end

  // hash state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bits_r <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= SHA_IV[i];
      end
    end else begin
      pos_r  <= pos_nxt;
      bits_r <= bits_nxt;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  // block and working variables
  always_ff @(posedge clk) begin
    block_r <= block_nxt;
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

  assign stat.pos = pos_r;
  assign out_word = chain_r[cmd.out_idx];

endmodule

[rtl/sha256_hash_unit.sv]
// SHA-256 hasher, one message byte per input request.
// Input channel: in_tdata carries the byte, in_tuser says whether it is valid,
// in_tlast marks the end of the message (with or without a byte, so an empty
// message works).
// Output channel: eight requests per message, h0 first; out_tdata holds the
// digest word and its index, out_tlast flags the eighth word.
// Throughput: one byte per cycle while a block fills; the 64th byte of a block
// starts the compression, 64 rounds on one round unit and then a fold into
// the chaining value, and in_tready stays low until the fold is done.
// After in_tlast: the padding bytes (9 to 72 bytes, marker, zeros and the
// 64-bit length) are written, each extra block (one or two) is compressed,
// then the digest words follow, one per cycle while out_tready is high.
// While the digest is shown no input is accepted, and while out_tready is
// low the word on the output holds. After the eighth word the chaining value,
// bit count and byte position return to their initial values.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the bit count and byte position; no clearing sweep is needed.
module sha256_hash_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);

  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  out_idx;
  logic [31:0] out_word;

  // sequencer
  sha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_has_byte (in_tuser),
    .in_eom      (in_tlast),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_idx     (out_idx),
    .out_last    (out_tlast),
    .stat        (stat),
    .cmd         (cmd)
  );

  // block buffer, schedule and round unit
  sha_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_tdata),
    .stat     (stat),
    .out_word (out_word)
  );

  assign out_tdata = {5'd0, out_idx, out_word};

endmodule

[rtl/sha_checker.sv]
`include "sha256_hash_unit_assert.svh"

module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // stalled digest word holds
  `SHA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // no input taken while the digest is on the output
  `SHA_ASSERT_IMP(a_no_in_during_out, clk, rst_n, out_tvalid, !in_tready)

  // digest words come in index order without gaps
  `SHA_ASSERT_NXT(a_idx_step, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1))

  // nothing follows the eighth word
  `SHA_ASSERT_NXT(a_end_after_last, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)

endmodule

bind sha256_hash_unit sha_checker u_sha_checker (.*);

[tb/tb_sha256_hash_unit.sv]
module tb_sha256_hash_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // sha-256 round constants and initial hash value
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [7:0] MARKER_BYTE = 8'h80;
  localparam logic [5:0] LENGTH_AT   = 6'd56;

  // one row of directed stimulus; digest is h0 in the top bits
  typedef struct packed {
    logic [7:0]   data;
    logic         has;
    logic         eom;
    logic         typed;
    logic [255:0] digest;
  } stim_row_t;

  // per-message note from the sender: use the typed digest or the predictor
  typedef struct packed {
    logic         typed;
    logic [255:0] digest;
  } msg_note_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // predictor state
  logic [31:0]  hash_state [8];
  logic [31:0]  block_buf [16];
  logic [63:0]  bit_count;
  logic [5:0]   fill_pos;

  digest_word_t digest_due [$];
  msg_note_t    msg_notes [$];
  int           errors     = 0;
  int           burst_left = 0;
  int           ready_pct  = 100;
  int           ready_span = 0;

  stim_row_t directed_rows [14] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1,
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1,
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'ha5, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0}
  };

  sha256_hash_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // start of a new message
  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
    bit_count = '0;
    fill_pos  = '0;
  endtask

  // 64 rounds over the current block, folded into the chaining value
  task automatic hash_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  // big-endian byte placement, compress on a full block
  task automatic hash_absorb_byte(input logic [7:0] value);
    logic [3:0] wsel;
    logic [1:0] lane;
    wsel = fill_pos[5:2];
    lane = fill_pos[1:0];
    if (lane == 2'd0) begin
      block_buf[wsel] = {value, 24'h0};
    end else begin
      block_buf[wsel][8 * (3 - lane) +: 8] = value;
    end
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) hash_compress();
  endtask

  // one accepted request into the predictor; eight digest words on end of message
  task automatic hash_take_item(input logic [7:0] data, input logic has, input logic eom);
    logic [63:0] length_bits;
    msg_note_t   note;
    if (has) begin
      bit_count = bit_count + 64'd8;
      hash_absorb_byte(data);
    end
    if (eom) begin
      length_bits = bit_count;
      hash_absorb_byte(MARKER_BYTE);
      while (fill_pos != LENGTH_AT) hash_absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) hash_absorb_byte(length_bits[8 * i +: 8]);
      note = msg_notes.pop_front();
      for (int i = 0; i < 8; i++) begin
        digest_due.push_back('{note.typed ? note.digest[255 - 32 * i -: 32] : hash_state[i],
                               3'(i), i == 7});
      end
      hash_restart();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    errors++;
    $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
  endtask

  // compare one digest word against the oldest expectation
  task automatic check_digest_word();
    digest_word_t want;
    if (digest_due.size() == 0) begin
      report_mismatch("unexpected digest word", out_tdata, '0);
    end else begin
      want = digest_due.pop_front();
      if (out_tdata[31:0] !== want.word)
        report_mismatch("digest_word", 40'(out_tdata[31:0]), 40'(want.word));
      if (out_tdata[34:32] !== want.idx)
        report_mismatch("word_index", 40'(out_tdata[34:32]), 40'(want.idx));
      if (out_tlast !== want.last)
        report_mismatch("last_word", 40'(out_tlast), 40'(want.last));
      if (out_tdata[39:35] !== 5'd0)
        report_mismatch("tdata padding", 40'(out_tdata[39:35]), 40'(5'd0));
    end
  endtask

  // monitor: results first, then the accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_digest_word();
      if (in_tvalid && in_tready) hash_take_item(in_tdata, in_tuser, in_tlast);
    end
  end

  // receiver stalls, stall density changes every span
  always @(negedge clk) begin
    if (ready_span == 0) begin
      case ($urandom_range(0, 3))
        0, 1: ready_pct = 100;
        2:    ready_pct = 60;
        default: ready_pct = 20;
      endcase
      ready_span = $urandom_range(16, 96);
    end
    ready_span--;
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  // present one request, in bursts with random gaps
  task automatic send_item(input logic [7:0] data, input logic has, input logic eom,
                           input logic typed, input logic [255:0] digest);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    if (eom) msg_notes.push_back('{typed, digest});
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off the sender until every digest has come out
  task automatic drain_digests();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (digest_due.size() == 0 && msg_notes.size() == 0);
  endtask

  initial begin
    int msg_n;
    int sent;
    int len;
    logic tail_byte;
    hash_restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].data, directed_rows[r].has, directed_rows[r].eom,
                directed_rows[r].typed, directed_rows[r].digest);
    end
    drain_digests();

    // random messages; first two force a second padding block and an exact block
    msg_n = 0;
    sent  = 0;
    while (sent < 170 || msg_n < 6) begin
      if (msg_n == 0) begin
        len = 56;
      end else if (msg_n == 1) begin
        len = 64;
      end else begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(0, 3);
          1:       len = ($urandom_range(0, 1) != 0) ? 55 : 63;
          2:       len = $urandom_range(119, 121);
          default: len = $urandom_range(1, 40);
        endcase
      end
      tail_byte = (len > 0) && ($urandom_range(0, 1) != 0);
      if (msg_n == 3) drain_digests();
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        send_item(8'($urandom_range(0, 255)), 1'b1, tail_byte && (k == len - 1),
                  1'b0, '0);
        sent++;
      end
      if (!tail_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        sent++;
      end
      msg_n++;
    end

    drain_digests();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
